[hw/rtl/hbfd_pkg.sv]
// ----------------------------------------------------------------------------
// hbfd_pkg: shared types and constants of the heartbeat failure detector
// Request codes, register indexes, field widths and the peer verdict type.
// ----------------------------------------------------------------------------
package hbfd_pkg;

  localparam int AGE_W       = 8;
  localparam int CFG_W       = 8;
  localparam int IDX_W       = 3;
  localparam int MASK_W      = 8;
  localparam int OUT_EPOCH_W = 32;
  localparam int LIST_MAX    = 8;
  localparam int LIST_W      = $clog2(LIST_MAX);

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_TICK      = 2'd0,
    REQ_HEARTBEAT = 2'd1,
    REQ_REPLY     = 2'd2,
    REQ_UNUSED    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_SUSPECT = 2'd0,
    CFG_DEAD    = 2'd1,
    CFG_SELF    = 2'd2,
    CFG_SEED    = 2'd3
  } cfg_e;

  // verdict of one tick evaluation; kill implies suspect
  typedef struct packed {
    logic kill;
    logic suspect;
  } eval_t;

endpackage

[hw/rtl/hbfd_eval.sv]
// ----------------------------------------------------------------------------
// hbfd_eval: shared peer aging and threshold unit
// Saturating age increment and compare against the suspect and dead limits.
// ----------------------------------------------------------------------------
module hbfd_eval import hbfd_pkg::*; (
  input  logic [AGE_W-1:0] age_i,
  input  logic [CFG_W-1:0] suspect_ticks_i,
  input  logic [CFG_W-1:0] dead_ticks_i,
  output logic [AGE_W-1:0] age_o,
  output eval_t            eval_o
);

  always_comb begin
    age_o          = (age_i == AGE_MAX) ? age_i : age_i + AGE_W'(1);
    eval_o.kill    = age_o > dead_ticks_i;
    eval_o.suspect = (age_o > dead_ticks_i) || (age_o > suspect_ticks_i);
  end

endmodule

[hw/rtl/hbfd_table.sv]
// ----------------------------------------------------------------------------
// hbfd_table: per-peer age and seen-epoch storage
// One write and one registered read port; valid bits make unwritten
// entries, and seed-cleared age entries, read as zero.
// ----------------------------------------------------------------------------
module hbfd_table import hbfd_pkg::*; #(
  parameter int NUM_PEERS  = 8,
  parameter int EPOCH_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [$clog2(NUM_PEERS)-1:0] rd_addr_i,
  output logic [AGE_W-1:0]             age_rdata_o,
  output logic [EPOCH_BITS-1:0]        seen_rdata_o,
  input  logic [$clog2(NUM_PEERS)-1:0] wr_addr_i,
  input  logic                         age_we_i,
  input  logic [AGE_W-1:0]             age_wdata_i,
  input  logic                         seen_we_i,
  input  logic [EPOCH_BITS-1:0]        seen_wdata_i,
  input  logic [NUM_PEERS-1:0]         age_clr_i
);

  logic [AGE_W-1:0]      age_mem  [NUM_PEERS];
  logic [EPOCH_BITS-1:0] seen_mem [NUM_PEERS];

  logic [NUM_PEERS-1:0]  age_vld_q, age_vld_d;
  logic [NUM_PEERS-1:0]  seen_vld_q, seen_vld_d;
  logic [AGE_W-1:0]      age_rd_q;
  logic [EPOCH_BITS-1:0] seen_rd_q;
  logic                  age_rd_vld_q, seen_rd_vld_q;

  always_comb begin
    age_vld_d  = age_vld_q & ~age_clr_i;
    seen_vld_d = seen_vld_q;
    if (age_we_i) begin
      age_vld_d[wr_addr_i] = 1'b1;
    end
    if (seen_we_i) begin
      seen_vld_d[wr_addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_vld_q     <= '0;
      seen_vld_q    <= '0;
      age_rd_vld_q  <= 1'b0;
      seen_rd_vld_q <= 1'b0;
    end else begin
      age_vld_q     <= age_vld_d;
      seen_vld_q    <= seen_vld_d;
      age_rd_vld_q  <= age_vld_q[rd_addr_i];
      seen_rd_vld_q <= seen_vld_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (age_we_i) begin
      age_mem[wr_addr_i] <= age_wdata_i;
    end
    if (seen_we_i) begin
      seen_mem[wr_addr_i] <= seen_wdata_i;
    end
    age_rd_q  <= age_mem[rd_addr_i];
    seen_rd_q <= seen_mem[rd_addr_i];
  end

  assign age_rdata_o  = age_rd_vld_q ? age_rd_q : '0;
  assign seen_rdata_o = seen_rd_vld_q ? seen_rd_q : '0;

endmodule

[hw/rtl/heartbeat_failure_detector_unit.sv]
// ----------------------------------------------------------------------------
// heartbeat_failure_detector_unit: heartbeat timeout failure detector
// Peer table with tick aging, suspect/dead classification and epoch tracking.
// ----------------------------------------------------------------------------
// Usage:
//   An item (req_type_i, peer_index_i) is taken on a clock edge with start
//   high and busy low. busy stays high until the item's final result has
//   been produced. Results appear on the result ports for one cycle each,
//   marked by res_valid_o; last_o flags the final one. The receiver cannot
//   stall, so results are never held.
//   Tick: the sequencer walks the peer table one entry per cycle through
//   the shared aging/compare unit, then gives one result.
//   Heartbeat: a refresh state, then a table walk that reads one entry
//   per cycle and lists each alive peer as one result. Reply and other
//   items: one result.
//   The walk is bound by the single read port of the age/epoch table.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect
//   at once and must be issued only while idle; the block does not check.
//   Reset clears the table, the epoch and the internal flags; thresholds
//   return to 5 and 15 ticks, self index and seed mask to zero.
// ----------------------------------------------------------------------------
module heartbeat_failure_detector_unit import hbfd_pkg::*; #(
  parameter int NUM_PEERS  = 8,
  parameter int EPOCH_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             req_type_i,
  input  logic [IDX_W-1:0]       peer_index_i,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  output logic                   res_valid_o,
  output logic [OUT_EPOCH_W-1:0] cur_epoch_o,
  output logic [MASK_W-1:0]      alive_mask_o,
  output logic [MASK_W-1:0]      suspected_mask_o,
  output logic [MASK_W-1:0]      newly_dead_mask_o,
  output logic                   membership_changed_o,
  output logic                   entry_valid_o,
  output logic [IDX_W-1:0]       entry_peer_o,
  output logic [OUT_EPOCH_W-1:0] entry_seen_epoch_o,
  output logic                   entry_suspected_o,
  output logic                   last_o
);

  localparam int PW = $clog2(NUM_PEERS);
  localparam int MW = (NUM_PEERS > MASK_W) ? NUM_PEERS : MASK_W;
  localparam int EW = (EPOCH_BITS > OUT_EPOCH_W) ? EPOCH_BITS : OUT_EPOCH_W;
  localparam int CW = (PW > IDX_W) ? PW : IDX_W;
  localparam logic [PW-1:0] LAST_IDX  = PW'(NUM_PEERS - 1);
  localparam logic [31:0]   NP        = 32'(NUM_PEERS);
  localparam logic [LIST_W-1:0] LIST_LAST = LIST_W'(LIST_MAX - 1);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_TICK      = 7'b0000010,
    S_TICK_LAST = 7'b0000100,
    S_TICK_OUT  = 7'b0001000,
    S_HB_REF    = 7'b0010000,
    S_HB_SCAN   = 7'b0100000,
    S_SINGLE    = 7'b1000000
  } state_e;

  function automatic logic [OUT_EPOCH_W-1:0] lo_epoch(input logic [EPOCH_BITS-1:0] v);
    logic [EW-1:0] w;
    w = EW'(v);
    return w[OUT_EPOCH_W-1:0];
  endfunction

  function automatic logic [MASK_W-1:0] lo_mask(input logic [NUM_PEERS-1:0] v);
    logic [MW-1:0] w;
    w = MW'(v);
    return w[MASK_W-1:0];
  endfunction

  state_e                state_q, state_d;
  logic [1:0]            type_q, type_d;
  logic [IDX_W-1:0]      p_q, p_d;
  logic [PW-1:0]         cnt_q, cnt_d;
  logic                  st_v_q;
  logic [PW-1:0]         st_idx_q;
  logic [LIST_W-1:0]     k_q, k_d;
  logic [NUM_PEERS-1:0]  known_q, known_d;
  logic [NUM_PEERS-1:0]  alive_q, alive_d;
  logic [NUM_PEERS-1:0]  susp_q, susp_d;
  logic [NUM_PEERS-1:0]  dead_mask_q, dead_mask_d;
  logic [EPOCH_BITS-1:0] epoch_q, epoch_d;
  logic [EPOCH_BITS-1:0] before_q, before_d;
  logic                  chg_q, chg_d;
  logic [CFG_W-1:0]      suspect_ticks_q, dead_ticks_q, seed_q;
  logic [IDX_W-1:0]      self_q;

  logic                  issue, proc, elig, revived, p_in_range, reply_ok;
  logic [PW-1:0]         pidx;
  logic [NUM_PEERS-1:0]  seed_vec, above;
  logic [MW-1:0]         seed_pad;

  logic [PW-1:0]         wr_addr;
  logic                  age_we, seen_we;
  logic [AGE_W-1:0]      age_wdata, age_rd, age_new;
  logic [EPOCH_BITS-1:0] seen_wdata, seen_rd;
  eval_t                 verdict;

  logic                  emit, o_chg, o_ev, o_susp, o_last;
  logic [OUT_EPOCH_W-1:0] o_epoch, o_seen;
  logic [MASK_W-1:0]     o_dead;
  logic [IDX_W-1:0]      o_peer;

  hbfd_table #(
    .NUM_PEERS  (NUM_PEERS),
    .EPOCH_BITS (EPOCH_BITS)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_addr_i    (cnt_q),
    .age_rdata_o  (age_rd),
    .seen_rdata_o (seen_rd),
    .wr_addr_i    (wr_addr),
    .age_we_i     (age_we),
    .age_wdata_i  (age_wdata),
    .seen_we_i    (seen_we),
    .seen_wdata_i (seen_wdata),
    .age_clr_i    (seed_vec)
  );

  hbfd_eval u_eval (
    .age_i           (age_rd),
    .suspect_ticks_i (suspect_ticks_q),
    .dead_ticks_i    (dead_ticks_q),
    .age_o           (age_new),
    .eval_o          (verdict)
  );

  assign busy       = (state_q != S_IDLE);
  assign pidx       = PW'(p_q);
  assign p_in_range = (32'(p_q) < NP);
  assign reply_ok   = (type_q == REQ_REPLY) && p_in_range && known_q[pidx] &&
                      (p_q != self_q) && seed_q[p_q];
  assign proc       = st_v_q && ((state_q == S_TICK) || (state_q == S_TICK_LAST) ||
                                 (state_q == S_HB_SCAN));
  assign elig       = (CW'(st_idx_q) != CW'(self_q)) && known_q[st_idx_q] &&
                      alive_q[st_idx_q];

  always_comb begin
    seed_pad = MW'(cfg_wdata_i);
    seed_vec = (cfg_we_i && (cfg_idx_i == CFG_SEED)) ? seed_pad[NUM_PEERS-1:0] : '0;
    for (int j = 0; j < NUM_PEERS; j++) begin
      above[j] = PW'(j) > st_idx_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    type_d      = type_q;
    p_d         = p_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    known_d     = known_q | seed_vec;
    alive_d     = alive_q | seed_vec;
    susp_d      = susp_q & ~seed_vec;
    dead_mask_d = dead_mask_q;
    epoch_d     = epoch_q;
    before_d    = before_q;
    chg_d       = chg_q;
    issue       = 1'b0;
    revived     = 1'b0;
    wr_addr     = st_idx_q;
    age_we      = 1'b0;
    age_wdata   = age_new;
    seen_we     = 1'b0;
    seen_wdata  = epoch_q;
    emit        = 1'b0;
    o_epoch     = '0;
    o_dead      = '0;
    o_chg       = 1'b0;
    o_ev        = 1'b0;
    o_peer      = '0;
    o_seen      = '0;
    o_susp      = 1'b0;
    o_last      = 1'b0;

    if (proc && (state_q != S_HB_SCAN)) begin
      age_we = 1'b1;
      if (elig) begin
        if (verdict.kill) begin
          alive_d[st_idx_q]     = 1'b0;
          susp_d[st_idx_q]      = 1'b1;
          dead_mask_d[st_idx_q] = 1'b1;
        end else begin
          susp_d[st_idx_q] = verdict.suspect;
        end
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          type_d      = req_type_i;
          p_d         = peer_index_i;
          cnt_d       = '0;
          k_d         = '0;
          dead_mask_d = '0;
          if (req_type_i == REQ_TICK) begin
            state_d = S_TICK;
          end else if ((req_type_i == REQ_HEARTBEAT) && (32'(peer_index_i) < NP)) begin
            state_d = S_HB_REF;
          end else begin
            state_d = S_SINGLE;
          end
        end
      end
      S_TICK: begin
        issue = 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = S_TICK_LAST;
        end else begin
          cnt_d = cnt_q + PW'(1);
        end
      end
      S_TICK_LAST: begin
        state_d = S_TICK_OUT;
      end
      S_TICK_OUT: begin
        if (|dead_mask_q) begin
          epoch_d = epoch_q + EPOCH_BITS'(1);
        end
        emit    = 1'b1;
        o_epoch = lo_epoch(epoch_d);
        o_dead  = lo_mask(dead_mask_q);
        o_chg   = |dead_mask_q;
        o_last  = 1'b1;
        state_d = S_IDLE;
      end
      S_HB_REF: begin
        revived       = !alive_q[pidx];
        known_d[pidx] = 1'b1;
        alive_d[pidx] = 1'b1;
        susp_d[pidx]  = 1'b0;
        wr_addr       = pidx;
        age_we        = 1'b1;
        age_wdata     = '0;
        seen_we       = 1'b1;
        before_d      = epoch_q;
        chg_d         = revived;
        if (revived) begin
          epoch_d = epoch_q + EPOCH_BITS'(1);
        end
        cnt_d   = '0;
        state_d = S_HB_SCAN;
      end
      S_HB_SCAN: begin
        issue = 1'b1;
        if (cnt_q != LAST_IDX) begin
          cnt_d = cnt_q + PW'(1);
        end
        if (proc && alive_q[st_idx_q]) begin
          emit    = 1'b1;
          o_epoch = lo_epoch(before_q);
          o_chg   = chg_q;
          o_ev    = 1'b1;
          o_peer  = IDX_W'(st_idx_q);
          o_seen  = lo_epoch(seen_rd);
          o_susp  = susp_q[st_idx_q];
          o_last  = (k_q == LIST_LAST) || !(|(alive_q & above));
          k_d     = k_q + LIST_W'(1);
          if (o_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_SINGLE: begin
        if (reply_ok) begin
          revived       = !alive_q[pidx];
          alive_d[pidx] = 1'b1;
          susp_d[pidx]  = 1'b0;
          wr_addr       = pidx;
          age_we        = 1'b1;
          age_wdata     = '0;
          seen_we       = 1'b1;
          if (revived) begin
            epoch_d = epoch_q + EPOCH_BITS'(1);
          end
        end
        emit    = 1'b1;
        o_epoch = lo_epoch(epoch_d);
        o_chg   = revived;
        o_last  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      type_q          <= REQ_TICK;
      p_q             <= '0;
      cnt_q           <= '0;
      st_v_q          <= 1'b0;
      st_idx_q        <= '0;
      k_q             <= '0;
      known_q         <= '0;
      alive_q         <= '0;
      susp_q          <= '0;
      dead_mask_q     <= '0;
      epoch_q         <= '0;
      before_q        <= '0;
      chg_q           <= 1'b0;
      suspect_ticks_q <= CFG_W'(5);
      dead_ticks_q    <= CFG_W'(15);
      self_q          <= '0;
      seed_q          <= '0;
      res_valid_o     <= 1'b0;
    end else begin
      state_q     <= state_d;
      type_q      <= type_d;
      p_q         <= p_d;
      cnt_q       <= cnt_d;
      st_v_q      <= issue;
      st_idx_q    <= cnt_q;
      k_q         <= k_d;
      known_q     <= known_d;
      alive_q     <= alive_d;
      susp_q      <= susp_d;
      dead_mask_q <= dead_mask_d;
      epoch_q     <= epoch_d;
      before_q    <= before_d;
      chg_q       <= chg_d;
      res_valid_o <= emit;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SUSPECT: suspect_ticks_q <= cfg_wdata_i;
          CFG_DEAD:    dead_ticks_q    <= cfg_wdata_i;
          CFG_SELF:    self_q          <= cfg_wdata_i[IDX_W-1:0];
          CFG_SEED:    seed_q          <= cfg_wdata_i;
          default:     seed_q          <= seed_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cur_epoch_o          <= o_epoch;
      alive_mask_o         <= lo_mask(alive_d);
      suspected_mask_o     <= lo_mask(susp_d);
      newly_dead_mask_o    <= o_dead;
      membership_changed_o <= o_chg;
      entry_valid_o        <= o_ev;
      entry_peer_o         <= o_peer;
      entry_seen_epoch_o   <= o_seen;
      entry_suspected_o    <= o_susp;
      last_o               <= o_last;
    end
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after item accept");

  a_open_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> busy)
    else $error("non-final result while idle");

  a_dead_bumps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (newly_dead_mask_o != '0)) |-> membership_changed_o)
    else $error("peer death without epoch change");

  a_listed_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && entry_valid_o) |-> alive_mask_o[entry_peer_o])
    else $error("listed peer not alive");

endmodule
